// File: sv/trme_pkg.sv
// Shared widths, opcode and status codes, and ALU control type for the execute block.
`default_nettype none

package trme_pkg;

   localparam int DATA_W   = 32;
   localparam int KIND_W   = 4;
   localparam int IDX_W    = 2;
   localparam int MADDR_W  = 4;
   localparam int TGT_W    = 8;
   localparam int PCOUT_W  = 8;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_ADD     = 4'd1;
   localparam logic [KIND_W-1:0] KIND_SUB     = 4'd2;
   localparam logic [KIND_W-1:0] KIND_STORE   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_MUL     = 4'd4;
   localparam logic [KIND_W-1:0] KIND_DIV     = 4'd5;
   localparam logic [KIND_W-1:0] KIND_JUMP    = 4'd6;
   localparam logic [KIND_W-1:0] KIND_PRINT   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_HALT    = 4'd8;
   localparam logic [KIND_W-1:0] KIND_RESTART = 4'd9;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DIV0    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

   typedef struct packed {
      logic sub;
   } alu_ctl_type;

endpackage

`default_nettype wire

// File: sv/trme_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module trme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: sv/trme_alu.sv
// Shared 33-bit add/subtract unit used by every arithmetic step of the sequencer.
`default_nettype none

module trme_alu (
   input  wire trme_pkg::alu_ctl_type              ctl,
   input  wire logic [trme_pkg::DATA_W-1:0]        op_a,
   input  wire logic [trme_pkg::DATA_W-1:0]        op_b,
   output logic      [trme_pkg::DATA_W:0]          sum
);

   import trme_pkg::*;

   always_comb begin
      if (ctl.sub) begin
         sum = {1'b0, op_a} - {1'b0, op_b};
      end else begin
         sum = {1'b0, op_a} + {1'b0, op_b};
      end
   end

endmodule

`default_nettype wire

// File: sv/toy_register_machine_execute.sv
// Top level: sequencer, register file and shared ALU of the register machine execute unit.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | kind, reg_a/b/c, use_three, immediate, ...
//   rsp     | out       | rsp_valid/rsp_stall | next_pc, halted, status, print, store, ...
//
// One request at a time. Load, jump, halt, restart, text forms, unknown opcodes and
// requests while halted go straight to the finish state; the others first read their
// operands from the register file. Mul and div run one bit per cycle through the shared
// 33-bit adder; register reads go one per cycle through the single RAM read port. Reset
// is synchronous and clears the register file through per-entry valid bits. A stalled
// result holds; the next result waits for it.
`default_nettype none

module toy_register_machine_execute #(
   parameter int REG_COUNT  = 4,
   parameter int MEM_DEPTH  = 16,
   parameter int PROG_DEPTH = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [trme_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [trme_pkg::IDX_W-1:0]        req_reg_a,
   input  wire logic [trme_pkg::IDX_W-1:0]        req_reg_b,
   input  wire logic [trme_pkg::IDX_W-1:0]        req_reg_c,
   input  wire logic                              req_use_three,
   input  wire logic signed [trme_pkg::DATA_W-1:0] req_immediate,
   input  wire logic [trme_pkg::MADDR_W-1:0]      req_mem_addr,
   input  wire logic [trme_pkg::TGT_W-1:0]        req_jump_target,
   input  wire logic                              req_has_text,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [trme_pkg::PCOUT_W-1:0]           rsp_next_pc,
   output logic                                   rsp_halted,
   output logic [trme_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                   rsp_print_valid,
   output logic signed [trme_pkg::DATA_W-1:0]     rsp_print_value,
   output logic                                   rsp_text_notice,
   output logic                                   rsp_store_valid,
   output logic [trme_pkg::MADDR_W-1:0]           rsp_store_addr,
   output logic signed [trme_pkg::DATA_W-1:0]     rsp_store_value
);

   import trme_pkg::*;

   localparam int RIDX_W = $clog2(REG_COUNT);
   localparam int PC_W   = $clog2(PROG_DEPTH);
   localparam int CNT_W  = $clog2(DATA_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OPX,
      ST_OPY,
      ST_ADD3_RD,
      ST_ADD3_WB,
      ST_MUL,
      ST_DIV_ABSX,
      ST_DIV_ABSY,
      ST_DIV,
      ST_DIV_FIX,
      ST_FINISH
   } state_type;

   function automatic logic [RIDX_W-1:0] ridx(input logic [IDX_W-1:0] f);
      logic [RIDX_W-1:0] r;
      r = '0;
      for (int i = 0; i < 2**IDX_W; i++) begin
         if (f == IDX_W'(i)) r = RIDX_W'(i % REG_COUNT);
      end
      return r;
   endfunction

   function automatic logic [MADDR_W-1:0] mwrap(input logic [MADDR_W-1:0] f);
      logic [MADDR_W-1:0] r;
      r = '0;
      for (int i = 0; i < 2**MADDR_W; i++) begin
         if (f == MADDR_W'(i)) r = MADDR_W'(i % MEM_DEPTH);
      end
      return r;
   endfunction

   function automatic logic [PC_W-1:0] twrap(input logic [TGT_W-1:0] f);
      logic [PC_W-1:0] r;
      r = '0;
      for (int i = 0; i < 2**TGT_W; i++) begin
         if (f == TGT_W'(i)) r = PC_W'(i % PROG_DEPTH);
      end
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic                 run_ff, run_in;
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic                 rvld_ff, rvld_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [RIDX_W-1:0]    a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic                 add3_ff, add3_in;
   logic [MADDR_W-1:0]   maddr_ff, maddr_in;
   logic [DATA_W-1:0]    x_ff, x_in, y_ff, y_in, acc_ff, acc_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 qneg_ff, qneg_in;
   logic [STATUS_W-1:0]  st_status_ff, st_status_in;
   logic                 st_print_ff, st_print_in;
   logic                 st_text_ff, st_text_in;
   logic                 st_store_ff, st_store_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PCOUT_W-1:0]   rsp_pc_ff, rsp_pc_in;
   logic                 rsp_halted_ff, rsp_halted_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_pvalid_ff, rsp_pvalid_in;
   logic [DATA_W-1:0]    rsp_pvalue_ff, rsp_pvalue_in;
   logic                 rsp_text_ff, rsp_text_in;
   logic                 rsp_svalid_ff, rsp_svalid_in;
   logic [MADDR_W-1:0]   rsp_saddr_ff, rsp_saddr_in;
   logic [DATA_W-1:0]    rsp_svalue_ff, rsp_svalue_in;

   logic                 wr_en;
   logic [RIDX_W-1:0]    wr_addr;
   logic [DATA_W-1:0]    wr_data;
   logic [RIDX_W-1:0]    rd_addr;
   logic [DATA_W-1:0]    rd_data;
   logic [DATA_W-1:0]    rdval;
   alu_ctl_type          alu_ctl;
   logic [DATA_W-1:0]    alu_a, alu_b;
   logic [DATA_W:0]      alu_sum;
   logic [DATA_W-1:0]    shifted;
   logic                 qbit;

   trme_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REG_COUNT)
   ) u_regs (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   trme_alu u_alu (
      .ctl  (alu_ctl),
      .op_a (alu_a),
      .op_b (alu_b),
      .sum  (alu_sum)
   );

   assign rdval     = rvld_ff ? rd_data : '0;
   assign shifted   = {acc_ff[DATA_W-2:0], x_ff[DATA_W-1]};
   assign qbit      = ~alu_sum[DATA_W];
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      run_in       = run_ff;
      valid_in     = valid_ff;
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      add3_in      = add3_ff;
      maddr_in     = maddr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      qneg_in      = qneg_ff;
      st_status_in = st_status_ff;
      st_print_in  = st_print_ff;
      st_text_in   = st_text_ff;
      st_store_in  = st_store_ff;

      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_pc_in     = rsp_pc_ff;
      rsp_halted_in = rsp_halted_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pvalid_in = rsp_pvalid_ff;
      rsp_pvalue_in = rsp_pvalue_ff;
      rsp_text_in   = rsp_text_ff;
      rsp_svalid_in = rsp_svalid_ff;
      rsp_saddr_in  = rsp_saddr_ff;
      rsp_svalue_in = rsp_svalue_ff;

      wr_en       = 1'b0;
      wr_addr     = a_ff;
      wr_data     = alu_sum[DATA_W-1:0];
      rd_addr     = a_ff;
      alu_ctl.sub = 1'b0;
      alu_a       = x_ff;
      alu_b       = y_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_kind == KIND_ADD && req_use_three) ? ridx(req_reg_b)
                                                                : ridx(req_reg_a);
            if (req_valid) begin
               kind_in      = req_kind;
               a_in         = ridx(req_reg_a);
               b_in         = ridx(req_reg_b);
               c_in         = ridx(req_reg_c);
               add3_in      = (req_kind == KIND_ADD) && req_use_three;
               maddr_in     = mwrap(req_mem_addr);
               st_status_in = STATUS_OK;
               st_print_in  = 1'b0;
               st_text_in   = 1'b0;
               st_store_in  = 1'b0;
               state_in     = ST_FINISH;
               if (req_kind == KIND_RESTART) begin
                  pc_in  = '0;
                  run_in = 1'b1;
               end else if (run_ff) begin
                  pc_in = (pc_ff == PC_W'(PROG_DEPTH - 1)) ? '0 : pc_ff + 1'b1;
                  unique case (req_kind)
                     KIND_LOAD: begin
                        if (req_has_text) begin
                           st_text_in = 1'b1;
                        end else begin
                           wr_en   = 1'b1;
                           wr_addr = ridx(req_reg_a);
                           wr_data = req_immediate;
                        end
                     end
                     KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_STORE: begin
                        state_in = ST_OPX;
                     end
                     KIND_PRINT: begin
                        if (req_has_text) st_text_in = 1'b1;
                        else              state_in   = ST_OPX;
                     end
                     KIND_JUMP: begin
                        pc_in = twrap(req_jump_target);
                     end
                     KIND_HALT: begin
                        run_in = 1'b0;
                     end
                     default: begin
                        run_in       = 1'b0;
                        st_status_in = STATUS_UNKNOWN;
                     end
                  endcase
               end
            end
         end
         ST_OPX: begin
            x_in    = rdval;
            rd_addr = add3_ff ? c_ff : b_ff;
            if (kind_ff == KIND_STORE) begin
               st_store_in = 1'b1;
               state_in    = ST_FINISH;
            end else if (kind_ff == KIND_PRINT) begin
               st_print_in = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               state_in = ST_OPY;
            end
         end
         ST_OPY: begin
            alu_b    = rdval;
            state_in = ST_FINISH;
            unique case (kind_ff)
               KIND_ADD: begin
                  wr_en = 1'b1;
                  if (add3_ff) begin
                     wr_addr  = b_ff;
                     y_in     = alu_sum[DATA_W-1:0];
                     state_in = ST_ADD3_RD;
                  end
               end
               KIND_SUB: begin
                  alu_ctl.sub = 1'b1;
                  wr_en       = 1'b1;
               end
               KIND_MUL: begin
                  acc_in   = '0;
                  y_in     = rdval;
                  cnt_in   = '0;
                  state_in = ST_MUL;
               end
               KIND_DIV: begin
                  if (rdval == '0) begin
                     run_in       = 1'b0;
                     st_status_in = STATUS_DIV0;
                  end else begin
                     y_in     = rdval;
                     qneg_in  = x_ff[DATA_W-1] ^ rdval[DATA_W-1];
                     state_in = ST_DIV_ABSX;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_ADD3_RD: begin
            rd_addr  = a_ff;
            state_in = ST_ADD3_WB;
         end
         ST_ADD3_WB: begin
            alu_a    = rdval;
            wr_en    = 1'b1;
            state_in = ST_FINISH;
         end
         ST_MUL: begin
            alu_a  = acc_ff;
            alu_b  = x_ff;
            acc_in = y_ff[0] ? alu_sum[DATA_W-1:0] : acc_ff;
            x_in   = x_ff << 1;
            y_in   = y_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_W - 1)) begin
               wr_en    = 1'b1;
               wr_data  = acc_in;
               state_in = ST_FINISH;
            end
         end
         ST_DIV_ABSX: begin
            alu_ctl.sub = 1'b1;
            alu_a       = '0;
            alu_b       = x_ff;
            if (x_ff[DATA_W-1]) x_in = alu_sum[DATA_W-1:0];
            state_in    = ST_DIV_ABSY;
         end
         ST_DIV_ABSY: begin
            alu_ctl.sub = 1'b1;
            alu_a       = '0;
            alu_b       = y_ff;
            if (y_ff[DATA_W-1]) y_in = alu_sum[DATA_W-1:0];
            acc_in      = '0;
            cnt_in      = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            alu_ctl.sub = 1'b1;
            alu_a       = shifted;
            alu_b       = y_ff;
            acc_in      = qbit ? alu_sum[DATA_W-1:0] : shifted;
            x_in        = {x_ff[DATA_W-2:0], qbit};
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_W - 1)) state_in = ST_DIV_FIX;
         end
         ST_DIV_FIX: begin
            alu_ctl.sub = 1'b1;
            alu_a       = '0;
            alu_b       = x_ff;
            wr_en       = 1'b1;
            wr_data     = qneg_ff ? alu_sum[DATA_W-1:0] : x_ff;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_pc_in     = PCOUT_W'(pc_ff);
               rsp_halted_in = ~run_ff;
               rsp_status_in = st_status_ff;
               rsp_pvalid_in = st_print_ff;
               rsp_pvalue_in = st_print_ff ? x_ff : '0;
               rsp_text_in   = st_text_ff;
               rsp_svalid_in = st_store_ff;
               rsp_saddr_in  = st_store_ff ? maddr_ff : '0;
               rsp_svalue_in = st_store_ff ? x_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (wr_en) valid_in[wr_addr] = 1'b1;
      rvld_in = valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      add3_ff       <= add3_in;
      maddr_ff      <= maddr_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      acc_ff        <= acc_in;
      cnt_ff        <= cnt_in;
      qneg_ff       <= qneg_in;
      st_status_ff  <= st_status_in;
      st_print_ff   <= st_print_in;
      st_text_ff    <= st_text_in;
      st_store_ff   <= st_store_in;
      rvld_ff       <= rvld_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_halted_ff <= rsp_halted_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
      rsp_pvalue_ff <= rsp_pvalue_in;
      rsp_text_ff   <= rsp_text_in;
      rsp_svalid_ff <= rsp_svalid_in;
      rsp_saddr_ff  <= rsp_saddr_in;
      rsp_svalue_ff <= rsp_svalue_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         run_ff       <= 1'b1;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         run_ff       <= run_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_pc_ff;
   assign rsp_halted      = rsp_halted_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_print_valid = rsp_pvalid_ff;
   assign rsp_print_value = rsp_pvalue_ff;
   assign rsp_text_notice = rsp_text_ff;
   assign rsp_store_valid = rsp_svalid_ff;
   assign rsp_store_addr  = rsp_saddr_ff;
   assign rsp_store_value = rsp_svalue_ff;

endmodule

`default_nettype wire

// File: sv/trme_checker.sv
// Port-level checker for the execute block, bound to the top level.
`default_nettype none

module trme_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic [trme_pkg::KIND_W-1:0]        req_kind,
   input wire logic [trme_pkg::IDX_W-1:0]         req_reg_a,
   input wire logic [trme_pkg::IDX_W-1:0]         req_reg_b,
   input wire logic [trme_pkg::IDX_W-1:0]         req_reg_c,
   input wire logic                               req_use_three,
   input wire logic signed [trme_pkg::DATA_W-1:0] req_immediate,
   input wire logic [trme_pkg::MADDR_W-1:0]       req_mem_addr,
   input wire logic [trme_pkg::TGT_W-1:0]         req_jump_target,
   input wire logic                               req_has_text,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [trme_pkg::PCOUT_W-1:0]       rsp_next_pc,
   input wire logic                               rsp_halted,
   input wire logic [trme_pkg::STATUS_W-1:0]      rsp_status,
   input wire logic                               rsp_print_valid,
   input wire logic signed [trme_pkg::DATA_W-1:0] rsp_print_value,
   input wire logic                               rsp_text_notice,
   input wire logic                               rsp_store_valid,
   input wire logic [trme_pkg::MADDR_W-1:0]       rsp_store_addr,
   input wire logic signed [trme_pkg::DATA_W-1:0] rsp_store_value
);

   import trme_pkg::*;

   // one request in flight: intake closes right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_pc)
         && $stable(rsp_status) && $stable(rsp_print_value) && $stable(rsp_store_value))
      else $error("stalled response changed");

   a_idle_events_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_store_valid || (rsp_store_addr == '0 && rsp_store_value == '0))
         && (rsp_print_valid || rsp_print_value == '0))
      else $error("event payload nonzero without event");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_halted && !rsp_store_valid
         && !rsp_print_valid && !rsp_text_notice)
      else $error("error status without halt or with events");

endmodule

bind toy_register_machine_execute trme_checker u_trme_checker (.*);

`default_nettype wire

// File: tb/retire_checker.sv
// Checker for the register machine execute unit: predicts each retirement and compares.
module retire_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [trme_pkg::KIND_W-1:0]   req_kind,
   input  logic [trme_pkg::IDX_W-1:0]    req_reg_a,
   input  logic [trme_pkg::IDX_W-1:0]    req_reg_b,
   input  logic [trme_pkg::IDX_W-1:0]    req_reg_c,
   input  logic                          req_use_three,
   input  logic [trme_pkg::DATA_W-1:0]   req_immediate,
   input  logic [trme_pkg::MADDR_W-1:0]  req_mem_addr,
   input  logic [trme_pkg::TGT_W-1:0]    req_jump_target,
   input  logic                          req_has_text,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [trme_pkg::PCOUT_W-1:0]  rsp_next_pc,
   input  logic                          rsp_halted,
   input  logic [trme_pkg::STATUS_W-1:0] rsp_status,
   input  logic                          rsp_print_valid,
   input  logic [trme_pkg::DATA_W-1:0]   rsp_print_value,
   input  logic                          rsp_text_notice,
   input  logic                          rsp_store_valid,
   input  logic [trme_pkg::MADDR_W-1:0]  rsp_store_addr,
   input  logic [trme_pkg::DATA_W-1:0]   rsp_store_value,
   output int                            mismatch_count,
   output int                            retires_pending,
   output int                            retires_checked
);

   import trme_pkg::*;

   typedef struct packed {
      logic [PCOUT_W-1:0]  next_pc;
      logic                halted;
      logic [STATUS_W-1:0] status;
      logic                print_valid;
      logic [DATA_W-1:0]   print_value;
      logic                text_notice;
      logic                store_valid;
      logic [MADDR_W-1:0]  store_addr;
      logic [DATA_W-1:0]   store_value;
   } retire_type;

   logic [DATA_W-1:0]  regs [4];
   logic [PCOUT_W-1:0] pc;
   logic               running;
   retire_type         expected_retires [$];
   int                 errors;
   int                 checked;

   function automatic retire_type execute_instr(input logic [KIND_W-1:0] kind,
                                                input logic [IDX_W-1:0] ra,
                                                input logic [IDX_W-1:0] rb,
                                                input logic [IDX_W-1:0] rc,
                                                input logic three,
                                                input logic [DATA_W-1:0] imm,
                                                input logic [MADDR_W-1:0] maddr,
                                                input logic [TGT_W-1:0] tgt,
                                                input logic text);
      retire_type r;
      r = '0;
      if (kind == KIND_RESTART) begin
         pc = '0;
         running = 1'b1;
      end else if (running) begin
         pc = pc + 1'b1;
         case (kind)
            KIND_LOAD: begin
               if (text) r.text_notice = 1'b1;
               else regs[ra] = imm;
            end
            KIND_ADD: begin
               // three-operand form is sequential, aliasing sees the first write
               if (three) begin
                  regs[rb] = regs[rb] + regs[rc];
                  regs[ra] = regs[ra] + regs[rb];
               end else begin
                  regs[ra] = regs[ra] + regs[rb];
               end
            end
            KIND_SUB: regs[ra] = regs[ra] - regs[rb];
            KIND_STORE: begin
               r.store_valid = 1'b1;
               r.store_addr  = maddr;
               r.store_value = regs[ra];
            end
            KIND_MUL: regs[ra] = regs[ra] * regs[rb];
            KIND_DIV: begin
               if (regs[rb] == '0) begin
                  running  = 1'b0;
                  r.status = STATUS_DIV0;
               end else if (regs[ra] == 32'h8000_0000 && regs[rb] == '1) begin
                  regs[ra] = 32'h8000_0000;
               end else begin
                  regs[ra] = $signed(regs[ra]) / $signed(regs[rb]);
               end
            end
            KIND_JUMP: pc = tgt;
            KIND_PRINT: begin
               if (text) begin
                  r.text_notice = 1'b1;
               end else begin
                  r.print_valid = 1'b1;
                  r.print_value = regs[ra];
               end
            end
            KIND_HALT: running = 1'b0;
            default: begin
               running  = 1'b0;
               r.status = STATUS_UNKNOWN;
            end
         endcase
      end
      r.next_pc = pc;
      r.halted  = !running;
      return r;
   endfunction

   function automatic string describe(input retire_type r);
      return $sformatf("pc=%0d halted=%0b status=%0d print=%0b/%0d notice=%0b store=%0b/%0d/%0d",
                       r.next_pc, r.halted, r.status, r.print_valid, $signed(r.print_value),
                       r.text_notice, r.store_valid, r.store_addr, $signed(r.store_value));
   endfunction

   always @(posedge clock) begin : monitor
      retire_type got;
      retire_type want;
      if (reset) begin
         foreach (regs[i]) regs[i] = '0;
         pc      = '0;
         running = 1'b1;
         expected_retires.delete();
         errors  = 0;
         checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_next_pc, rsp_halted, rsp_status, rsp_print_valid, rsp_print_value,
                   rsp_text_notice, rsp_store_valid, rsp_store_addr, rsp_store_value};
            if (expected_retires.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result: %s", describe(got));
            end else begin
               want = expected_retires.pop_front();
               checked++;
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch on result %0d\n  expected %s\n  actual   %s",
                              checked, describe(want), describe(got));
               end
            end
         end
         if (req_valid && !req_stall)
            expected_retires.push_back(execute_instr(req_kind, req_reg_a, req_reg_b, req_reg_c,
                                                     req_use_three, req_immediate, req_mem_addr,
                                                     req_jump_target, req_has_text));
      end
      mismatch_count  <= errors;
      retires_pending <= expected_retires.size();
      retires_checked <= checked;
   end

endmodule

// File: tb/testbench.sv
// Top of the execute unit testbench: clock, reset, instruction stimulus and verdict.
module testbench;
   import trme_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [IDX_W-1:0]   ra;
      logic [IDX_W-1:0]   rb;
      logic [IDX_W-1:0]   rc;
      logic               three;
      logic [DATA_W-1:0]  imm;
      logic [MADDR_W-1:0] maddr;
      logic [TGT_W-1:0]   tgt;
      logic               text;
   } instr_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [KIND_W-1:0]  req_kind;
   logic [IDX_W-1:0]   req_reg_a;
   logic [IDX_W-1:0]   req_reg_b;
   logic [IDX_W-1:0]   req_reg_c;
   logic               req_use_three;
   logic signed [DATA_W-1:0] req_immediate;
   logic [MADDR_W-1:0] req_mem_addr;
   logic [TGT_W-1:0]   req_jump_target;
   logic               req_has_text;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [PCOUT_W-1:0]  rsp_next_pc;
   logic                rsp_halted;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_print_valid;
   logic signed [DATA_W-1:0] rsp_print_value;
   logic                rsp_text_notice;
   logic                rsp_store_valid;
   logic [MADDR_W-1:0]  rsp_store_addr;
   logic signed [DATA_W-1:0] rsp_store_value;
   int mismatch_count;
   int retires_pending;
   int retires_checked;

   int idle_pct  = 0;
   int stall_pct = 0;
   int sent      = 0;
   int divides   = 0;
   int stops     = 0;
   int restarts  = 0;

   toy_register_machine_execute dut (.*);
   retire_checker checker_i (.*);

   always #2 clock = ~clock;

   always @(negedge clock)
      rsp_stall <= !reset && stall_pct != 0 && $urandom_range(99) < stall_pct;

   initial begin
      #3_000_000;
      $display("timeout with %0d results outstanding", retires_pending);
      $display("== FAIL ==");
      $finish;
   end

   function automatic instr_type random_instr();
      instr_type ins;
      ins.kind  = KIND_W'($urandom_range(15));
      ins.ra    = IDX_W'($urandom_range(3));
      ins.rb    = IDX_W'($urandom_range(3));
      ins.rc    = IDX_W'($urandom_range(3));
      ins.three = 1'($urandom_range(1));
      case ($urandom_range(7))
         0: ins.imm = '0;
         1: ins.imm = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         2, 3: ins.imm = $urandom_range(40) - 20;
         default: ins.imm = $urandom();
      endcase
      ins.maddr = MADDR_W'($urandom_range(15));
      ins.tgt   = TGT_W'($urandom_range(255));
      ins.text  = ($urandom_range(3) == 0);
      return ins;
   endfunction

   function automatic instr_type op(input logic [KIND_W-1:0] kind, input int ra, input int rb,
                                    input logic [DATA_W-1:0] imm);
      instr_type ins;
      ins       = random_instr();
      ins.kind  = kind;
      ins.ra    = IDX_W'(ra);
      ins.rb    = IDX_W'(rb);
      ins.imm   = imm;
      ins.three = 1'b0;
      ins.text  = 1'b0;
      return ins;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic issue(input instr_type ins);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_kind        <= ins.kind;
      req_reg_a       <= ins.ra;
      req_reg_b       <= ins.rb;
      req_reg_c       <= ins.rc;
      req_use_three   <= ins.three;
      req_immediate   <= ins.imm;
      req_mem_addr    <= ins.maddr;
      req_jump_target <= ins.tgt;
      req_has_text    <= ins.text;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent++;
      if (ins.kind == KIND_DIV) divides++;
      if (ins.kind == KIND_HALT || ins.kind > KIND_RESTART) stops++;
      if (ins.kind == KIND_RESTART) restarts++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (retires_pending != 0) @(negedge clock);
   endtask

   initial begin
      instr_type ins;
      logic      maybe_halted;
      int        roll;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_LOAD;
      req_reg_a       = '0;
      req_reg_b       = '0;
      req_reg_c       = '0;
      req_use_three   = 1'b0;
      req_immediate   = '0;
      req_mem_addr    = '0;
      req_jump_target = '0;
      req_has_text    = 1'b0;
      maybe_halted    = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      issue(op(KIND_LOAD, 0, 0, 32'h7fff_ffff));
      issue(op(KIND_LOAD, 1, 0, 32'h8000_0000));
      issue(op(KIND_LOAD, 2, 0, 32'hffff_ffff));
      ins = op(KIND_LOAD, 3, 0, 32'h1234_5678);
      ins.text = 1'b1;
      issue(ins);
      issue(op(KIND_ADD, 0, 1, 0));
      ins = op(KIND_ADD, 3, 2, 0);
      ins.rc = 2;
      ins.three = 1'b1;
      issue(ins);
      ins = op(KIND_ADD, 1, 1, 0);
      ins.rc = 0;
      ins.three = 1'b1;
      issue(ins);
      issue(op(KIND_SUB, 0, 1, 0));
      issue(op(KIND_MUL, 2, 1, 0));
      issue(op(KIND_LOAD, 3, 0, 32'h8000_0000));
      issue(op(KIND_LOAD, 2, 0, 32'hffff_ffff));
      issue(op(KIND_DIV, 3, 2, 0));
      issue(op(KIND_LOAD, 0, 0, -7));
      issue(op(KIND_LOAD, 1, 0, 2));
      issue(op(KIND_DIV, 0, 1, 0));
      ins = op(KIND_STORE, 0, 0, 0);
      ins.maddr = 4'hf;
      issue(ins);
      ins = op(KIND_STORE, 3, 0, 0);
      ins.maddr = 4'h0;
      issue(ins);
      issue(op(KIND_PRINT, 0, 0, 0));
      ins = op(KIND_PRINT, 1, 0, 0);
      ins.text = 1'b1;
      issue(ins);
      ins = op(KIND_JUMP, 0, 0, 0);
      ins.tgt = 8'hff;
      issue(ins);
      issue(op(KIND_HALT, 0, 0, 0));
      issue(op(KIND_LOAD, 2, 0, 99));
      issue(op(KIND_RESTART, 0, 0, 0));
      issue(op(KIND_LOAD, 1, 0, 0));
      issue(op(KIND_DIV, 0, 1, 0));
      issue(op(KIND_RESTART, 0, 0, 0));
      issue(op(4'hf, 0, 0, 0));
      issue(op(KIND_RESTART, 0, 0, 0));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 57; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         for (int n = 0; n < 450; n++) begin
            ins  = random_instr();
            roll = $urandom_range(99);
            // after a possible halt, restart soon so most requests execute
            if (maybe_halted && $urandom_range(1) == 1) ins.kind = KIND_RESTART;
            else if (roll < 24 || roll >= 97)           ins.kind = KIND_LOAD;
            else if (roll < 36)                         ins.kind = KIND_ADD;
            else if (roll < 44)                         ins.kind = KIND_SUB;
            else if (roll < 52)                         ins.kind = KIND_STORE;
            else if (roll < 60)                         ins.kind = KIND_MUL;
            else if (roll < 70)                         ins.kind = KIND_DIV;
            else if (roll < 75)                         ins.kind = KIND_JUMP;
            else if (roll < 84)                         ins.kind = KIND_PRINT;
            else if (roll < 87)                         ins.kind = KIND_HALT;
            else if (roll < 94)                         ins.kind = KIND_RESTART;
            else ins.kind = KIND_W'($urandom_range(15, 10));
            if (ins.kind == KIND_RESTART) maybe_halted = 1'b0;
            else if (ins.kind == KIND_DIV || ins.kind == KIND_HALT || ins.kind > KIND_RESTART)
               maybe_halted = 1'b1;
            issue(ins);
         end
         drain();
      end

      idle_pct  = 0;
      stall_pct = 0;
      repeat (50) @(negedge clock);
      $display("Sent %0d instructions (%0d divides, %0d halts or unknown opcodes, %0d restarts)",
               sent, divides, stops, restarts);
      $display("over four sender/receiver idle mixes; %0d results checked, %0d mismatches",
               retires_checked, mismatch_count);
      if (mismatch_count == 0 && retires_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
